/* rtl/core/ttcbm_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and helper functions for the brake controller mux
// no dependencies; used by every module of the block

package ttcbm_pkg;

  // driver mux geometry
  localparam int MUX_WIDTH    = 8;
  localparam int RESULT_MUX_W = 8;
  localparam int SLOT_W       = 3;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int LIMIT_W     = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_JOYSTICK_SLOT    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEYBOARD_SLOT    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_RANDOM_WALK_SLOT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BRAKE_SLOT       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_NAVIGATION_SLOT  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_TTC_LIMIT        = 3'd5;

  localparam logic [SLOT_W-1:0]  JOYSTICK_SLOT_RESET    = 3'd0;
  localparam logic [SLOT_W-1:0]  KEYBOARD_SLOT_RESET    = 3'd1;
  localparam logic [SLOT_W-1:0]  RANDOM_WALK_SLOT_RESET = 3'd2;
  localparam logic [SLOT_W-1:0]  BRAKE_SLOT_RESET       = 3'd3;
  localparam logic [SLOT_W-1:0]  NAVIGATION_SLOT_RESET  = 3'd4;
  localparam logic [LIMIT_W-1:0] TTC_LIMIT_RESET        = 16'd10;

  // button bit positions
  localparam int BTN_JOYSTICK    = 0;
  localparam int BTN_KEYBOARD    = 1;
  localparam int BTN_BRAKE_ARM   = 2;
  localparam int BTN_RANDOM_WALK = 3;
  localparam int BTN_NAVIGATION  = 4;

  // time to collision arithmetic
  localparam int DIST_W    = 16;
  localparam int SPEED_W   = 16;
  localparam int PROJ_W    = 2 * SPEED_W;
  localparam int APROJ_W   = PROJ_W - 1;
  localparam int MS_SCALE  = 1000;
  localparam int SCALE_W   = 10;
  localparam int Q15_SHIFT = 15;
  localparam int LHS_W     = DIST_W + SCALE_W;
  localparam int RHS_W     = LIMIT_W + APROJ_W;
  localparam int COUNT_W   = 16;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    CMD_BUTTONS  = 2'd0,
    CMD_BRAKE    = 2'd1,
    CMD_BEAM     = 2'd2,
    CMD_ODOMETRY = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                      cmd;
    logic [4:0]                buttons;
    logic                      brake_request;
    logic [DIST_W-1:0]         beam_range;
    logic [DIST_W-1:0]         beam_car_distance;
    logic signed [SPEED_W-1:0] beam_cosine;
    logic                      beam_last;
    logic signed [SPEED_W-1:0] speed;
  } item_t;

  typedef struct packed {
    logic [RESULT_MUX_W-1:0] mux_select;
    logic                    mux_published;
    logic                    safety_armed;
    logic                    collision_flag;
    logic                    collision_now;
    logic [COUNT_W-1:0]      collision_total;
    logic                    last;
  } result_t;

  // classified work item handed from front to back
  typedef struct packed {
    cmd_t                      kind;
    logic [4:0]                buttons;
    logic                      chain_pub;
    logic                      brake_request;
    logic [DIST_W-1:0]         abs_num;
    logic                      num_neg;
    logic                      num_pos;
    logic signed [SPEED_W-1:0] beam_cosine;
    logic                      beam_last;
    logic signed [SPEED_W-1:0] speed;
  } op_t;

  // one-hot bit for a slot; a slot beyond the mux shifts out to zero
  function automatic logic [MUX_WIDTH-1:0] slot_bit(input logic [SLOT_W-1:0] slot);
    logic [MUX_WIDTH-1:0] one;
    one = {{(MUX_WIDTH-1){1'b0}}, 1'b1};
    return one << slot;
  endfunction

  // clear the slot if set, otherwise select it alone
  function automatic logic [MUX_WIDTH-1:0] mux_toggle(input logic [MUX_WIDTH-1:0] mux,
                                                      input logic [SLOT_W-1:0] slot);
    logic [MUX_WIDTH-1:0] b;
    b = slot_bit(slot);
    if ((mux & b) != '0) begin
      return mux & ~b;
    end
    return b;
  endfunction

  // low bits of the mux as shown on a result
  function automatic logic [RESULT_MUX_W-1:0] mux_view(input logic [MUX_WIDTH-1:0] mux);
    logic [MUX_WIDTH+RESULT_MUX_W-1:0] ext;
    ext = {{RESULT_MUX_W{1'b0}}, mux};
    return ext[RESULT_MUX_W-1:0];
  endfunction

endpackage

/* rtl/core/ttcbm_front.sv */
`timescale 1ns / 1ps
// front end: takes input transfers and classifies them into work items
// depends on ttcbm_pkg

module ttcbm_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  ttcbm_pkg::item_t  item,
  output logic              op_valid,
  input  logic              queue_full,
  output ttcbm_pkg::op_t    op
);

  logic                           accept;
  logic [ttcbm_pkg::DIST_W:0]     diff;
  logic [ttcbm_pkg::DIST_W:0]     mag;
  ttcbm_pkg::op_t                 op_next;

  // hold the item while the queue is full
  assign item_stall = op_valid && queue_full;
  assign accept     = item_valid && !item_stall;

  // range minus car distance, kept as magnitude and sign
  always_comb begin
    diff = {1'b0, item.beam_range} - {1'b0, item.beam_car_distance};
    mag  = diff[ttcbm_pkg::DIST_W] ? ((ttcbm_pkg::DIST_W+1)'(0) - diff) : diff;
  end

  // classify the transfer
  always_comb begin
    op_next.kind          = item.cmd;
    op_next.buttons       = item.buttons;
    op_next.chain_pub     = item.buttons[ttcbm_pkg::BTN_KEYBOARD] ||
                            (!item.buttons[ttcbm_pkg::BTN_BRAKE_ARM] &&
                             (item.buttons[ttcbm_pkg::BTN_RANDOM_WALK] ||
                              item.buttons[ttcbm_pkg::BTN_NAVIGATION]));
    op_next.brake_request = item.brake_request;
    op_next.abs_num       = mag[ttcbm_pkg::DIST_W-1:0];
    op_next.num_neg       = diff[ttcbm_pkg::DIST_W];
    op_next.num_pos       = !diff[ttcbm_pkg::DIST_W] && (diff != '0);
    op_next.beam_cosine   = item.beam_cosine;
    op_next.beam_last     = item.beam_last;
    op_next.speed         = item.speed;
  end

  // holding register towards the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (accept) begin
      op_valid <= 1'b1;
    end else if (!queue_full) begin
      op_valid <= 1'b0;
    end
    if (accept) begin
      op <= op_next;
    end
  end

endmodule

/* rtl/core/ttcbm_queue.sv */
`timescale 1ns / 1ps
// short work queue between front and back end
// depends on ttcbm_pkg

module ttcbm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ttcbm_pkg::op_t  push_op,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output ttcbm_pkg::op_t  head
);

  ttcbm_pkg::op_t                mem [ttcbm_pkg::QUEUE_DEPTH];
  logic [ttcbm_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [ttcbm_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [ttcbm_pkg::QUEUE_AW:0]   fill;
  logic                           do_push;
  logic                           do_pop;

  assign full    = fill == (ttcbm_pkg::QUEUE_AW+1)'(ttcbm_pkg::QUEUE_DEPTH);
  assign valid   = fill != '0;
  assign head    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_op;
    end
  end

endmodule

/* rtl/core/ttcbm_back.sv */
`timescale 1ns / 1ps
// back end: driver mux, brake arm, collision test and result register
// depends on ttcbm_pkg

module ttcbm_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic [ttcbm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ttcbm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 op_valid,
  output logic                                 op_pop,
  input  ttcbm_pkg::op_t                       op_in,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output ttcbm_pkg::result_t                   result
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CMP,
    ST_RUN,
    ST_CHAIN
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [ttcbm_pkg::SLOT_W-1:0]  joystick_slot;
  logic [ttcbm_pkg::SLOT_W-1:0]  keyboard_slot;
  logic [ttcbm_pkg::SLOT_W-1:0]  random_walk_slot;
  logic [ttcbm_pkg::SLOT_W-1:0]  brake_slot;
  logic [ttcbm_pkg::SLOT_W-1:0]  navigation_slot;
  logic [ttcbm_pkg::LIMIT_W-1:0] ttc_limit;

  // architectural state
  logic [ttcbm_pkg::MUX_WIDTH-1:0] driver_mux, driver_mux_next;
  logic                            brake_armed, brake_armed_next;
  logic                            collision_status, collision_status_next;
  logic                            hit_in_scan, hit_in_scan_next;
  logic [ttcbm_pkg::COUNT_W-1:0]   collision_counter, collision_counter_next;
  logic signed [ttcbm_pkg::SPEED_W-1:0] current_speed, current_speed_next;

  // item in flight and arithmetic stages
  ttcbm_pkg::op_t                  op;
  logic [ttcbm_pkg::PROJ_W-1:0]    proj;
  logic [ttcbm_pkg::PROJ_W-1:0]    proj_mag;
  logic [ttcbm_pkg::LHS_W-1:0]     lhs;
  logic [ttcbm_pkg::RHS_W-1:0]     rhs;
  logic                            opposite;
  logic                            proj_zero;

  // combinational action
  logic [ttcbm_pkg::MUX_WIDTH-1:0] chain_mux;
  logic                            chain_armed;
  logic [ttcbm_pkg::MUX_WIDTH-1:0] brake_bit;
  logic                            beam_active;
  logic                            beam_hit;
  logic                            emit;
  logic                            emit_pub;
  logic                            emit_now;
  logic                            emit_last;
  logic                            emit_armed;
  logic                            out_free;
  ttcbm_pkg::result_t              result_next;

  assign out_free = !result_valid || !result_stall;
  assign op_pop   = (state == ST_IDLE) && op_valid;
  assign proj_mag = proj[ttcbm_pkg::PROJ_W-1] ? (ttcbm_pkg::PROJ_W'(0) - proj) : proj;
  assign brake_bit = ttcbm_pkg::slot_bit(brake_slot);

  // scaled distance against threshold times projected speed
  assign beam_active = !hit_in_scan && (current_speed != '0);
  assign beam_hit    = beam_active && !proj_zero && !opposite &&
                       (ttcbm_pkg::RHS_W'({lhs, {ttcbm_pkg::Q15_SHIFT{1'b0}}}) < rhs);

  // priority chain of the non-joystick buttons
  always_comb begin
    chain_mux   = driver_mux;
    chain_armed = brake_armed;
    priority if (op.buttons[ttcbm_pkg::BTN_KEYBOARD]) begin
      chain_mux = ttcbm_pkg::mux_toggle(driver_mux, keyboard_slot);
    end else if (op.buttons[ttcbm_pkg::BTN_BRAKE_ARM]) begin
      chain_armed = !brake_armed;
    end else if (op.buttons[ttcbm_pkg::BTN_RANDOM_WALK]) begin
      chain_mux = ttcbm_pkg::mux_toggle(driver_mux, random_walk_slot);
    end else if (op.buttons[ttcbm_pkg::BTN_NAVIGATION]) begin
      chain_mux = ttcbm_pkg::mux_toggle(driver_mux, navigation_slot);
    end else begin
      chain_mux = driver_mux;
    end
  end

  // sequencer actions and state updates
  always_comb begin
    state_next             = state;
    driver_mux_next        = driver_mux;
    brake_armed_next       = brake_armed;
    collision_status_next  = collision_status;
    hit_in_scan_next       = hit_in_scan;
    collision_counter_next = collision_counter;
    current_speed_next     = current_speed;
    emit                   = 1'b0;
    emit_pub               = 1'b0;
    emit_now               = 1'b0;
    emit_last              = 1'b1;
    emit_armed             = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (op_valid) begin
          state_next = (op_in.kind == ttcbm_pkg::CMD_BEAM) ? ST_MUL : ST_RUN;
        end
      end
      ST_MUL: begin
        state_next = ST_CMP;
      end
      ST_CMP: begin
        state_next = ST_RUN;
      end
      ST_RUN: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
          unique case (op.kind)
            ttcbm_pkg::CMD_BUTTONS: begin
              if (op.buttons[ttcbm_pkg::BTN_JOYSTICK]) begin
                driver_mux_next = ttcbm_pkg::mux_toggle(driver_mux, joystick_slot);
                emit_pub        = 1'b1;
                if (op.chain_pub) begin
                  emit_last  = 1'b0;
                  state_next = ST_CHAIN;
                end else begin
                  brake_armed_next = chain_armed;
                end
              end else begin
                driver_mux_next  = chain_mux;
                brake_armed_next = chain_armed;
                emit_pub         = op.chain_pub;
              end
            end
            ttcbm_pkg::CMD_BRAKE: begin
              if (op.brake_request && brake_armed) begin
                driver_mux_next = brake_bit;
                emit_pub        = 1'b1;
              end else if (!op.brake_request && ((driver_mux & brake_bit) != '0)) begin
                driver_mux_next = driver_mux & ~brake_bit;
              end
            end
            ttcbm_pkg::CMD_BEAM: begin
              if (beam_hit) begin
                driver_mux_next       = '0;
                brake_armed_next      = 1'b0;
                collision_status_next = 1'b1;
                hit_in_scan_next      = 1'b1;
                emit_pub              = 1'b1;
                emit_now              = 1'b1;
                if (collision_counter != '1) begin
                  collision_counter_next = collision_counter + 1'b1;
                end
              end else if (beam_active && op.beam_last) begin
                collision_status_next = 1'b0;
              end
              if (op.beam_last) begin
                hit_in_scan_next = 1'b0;
              end
            end
            ttcbm_pkg::CMD_ODOMETRY: begin
              current_speed_next = op.speed;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_CHAIN: begin
        if (out_free) begin
          emit             = 1'b1;
          emit_pub         = 1'b1;
          driver_mux_next  = chain_mux;
          brake_armed_next = chain_armed;
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // the joystick result goes out before the brake arm flips
    emit_armed = brake_armed_next;
    if (state == ST_RUN && op.kind == ttcbm_pkg::CMD_BUTTONS &&
        op.buttons[ttcbm_pkg::BTN_JOYSTICK]) begin
      emit_armed = brake_armed;
    end

    result_next.mux_select      = ttcbm_pkg::mux_view(driver_mux_next);
    result_next.mux_published   = emit_pub;
    result_next.safety_armed    = emit_armed;
    result_next.collision_flag  = collision_status_next;
    result_next.collision_now   = emit_now;
    result_next.collision_total = collision_counter_next;
    result_next.last            = emit_last;
  end

  // state, configuration and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      result_valid      <= 1'b0;
      driver_mux        <= '0;
      brake_armed       <= 1'b0;
      collision_status  <= 1'b0;
      hit_in_scan       <= 1'b0;
      collision_counter <= '0;
      current_speed     <= '0;
      joystick_slot     <= ttcbm_pkg::JOYSTICK_SLOT_RESET;
      keyboard_slot     <= ttcbm_pkg::KEYBOARD_SLOT_RESET;
      random_walk_slot  <= ttcbm_pkg::RANDOM_WALK_SLOT_RESET;
      brake_slot        <= ttcbm_pkg::BRAKE_SLOT_RESET;
      navigation_slot   <= ttcbm_pkg::NAVIGATION_SLOT_RESET;
      ttc_limit         <= ttcbm_pkg::TTC_LIMIT_RESET;
    end else begin
      state             <= state_next;
      driver_mux        <= driver_mux_next;
      brake_armed       <= brake_armed_next;
      collision_status  <= collision_status_next;
      hit_in_scan       <= hit_in_scan_next;
      collision_counter <= collision_counter_next;
      current_speed     <= current_speed_next;
      if (emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          ttcbm_pkg::CFG_JOYSTICK_SLOT:
            joystick_slot <= cfg_data[ttcbm_pkg::SLOT_W-1:0];
          ttcbm_pkg::CFG_KEYBOARD_SLOT:
            keyboard_slot <= cfg_data[ttcbm_pkg::SLOT_W-1:0];
          ttcbm_pkg::CFG_RANDOM_WALK_SLOT:
            random_walk_slot <= cfg_data[ttcbm_pkg::SLOT_W-1:0];
          ttcbm_pkg::CFG_BRAKE_SLOT:
            brake_slot <= cfg_data[ttcbm_pkg::SLOT_W-1:0];
          ttcbm_pkg::CFG_NAVIGATION_SLOT:
            navigation_slot <= cfg_data[ttcbm_pkg::SLOT_W-1:0];
          ttcbm_pkg::CFG_TTC_LIMIT:
            ttc_limit <= cfg_data[ttcbm_pkg::LIMIT_W-1:0];
          default: begin
          end
        endcase
      end
    end

    // item in flight
    if (op_pop) begin
      op <= op_in;
    end
    // projected speed: speed times cosine in Q15
    if (state == ST_MUL) begin
      proj <= ttcbm_pkg::PROJ_W'(current_speed) * ttcbm_pkg::PROJ_W'(op.beam_cosine);
    end
    // both sides of the threshold compare, plus sign check
    if (state == ST_CMP) begin
      lhs       <= ttcbm_pkg::LHS_W'(op.abs_num) * ttcbm_pkg::LHS_W'(ttcbm_pkg::MS_SCALE);
      rhs       <= ttcbm_pkg::RHS_W'(ttc_limit) *
                   ttcbm_pkg::RHS_W'(proj_mag[ttcbm_pkg::APROJ_W-1:0]);
      proj_zero <= proj == '0;
      opposite  <= (op.num_pos && proj[ttcbm_pkg::PROJ_W-1]) ||
                   (op.num_neg && !proj[ttcbm_pkg::PROJ_W-1] && (proj != '0));
    end
    if (emit) begin
      result <= result_next;
    end
  end

endmodule

/* rtl/core/ttc_brake_controller_mux_core.sv */
`timescale 1ns / 1ps
// top level of the driver mux and time-to-collision brake controller
// depends on ttcbm_pkg, ttcbm_front, ttcbm_queue and ttcbm_back

// Input transfers land in a front register that works out the beam distance
// difference and button priorities, then wait in a two-entry queue for the back
// end, which executes one item at a time. Buttons, brake requests and odometry
// go straight to the run state, plus a chain state when a button event publishes
// twice; a beam first passes states for the speed-times-cosine product and for
// the threshold products and compare. Results leave through a registered output,
// so input transfers are taken while a result waits, until queue and front fill.
// Configuration writes are always ready and take effect on the next cycle.

module ttc_brake_controller_mux_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  ttcbm_pkg::item_t                   item,
  output logic                               result_valid,
  input  logic                               result_stall,
  output ttcbm_pkg::result_t                 result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ttcbm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ttcbm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic           front_valid;
  logic           queue_full;
  logic           queue_valid;
  logic           queue_pop;
  ttcbm_pkg::op_t front_op;
  ttcbm_pkg::op_t queue_head;

  assign cfg_ready = 1'b1;

  // classify incoming transfers
  ttcbm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .op_valid   (front_valid),
    .queue_full (queue_full),
    .op         (front_op)
  );

  // decouple front and back
  ttcbm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (front_valid),
    .push_op (front_op),
    .full    (queue_full),
    .pop     (queue_pop),
    .valid   (queue_valid),
    .head    (queue_head)
  );

  // execute and deliver results
  ttcbm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .op_valid     (queue_valid),
    .op_pop       (queue_pop),
    .op_in        (queue_head),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

/* rtl/core/ttcbm_checker.sv */
`timescale 1ns / 1ps
// port-level checks on the result channel, bound to the top level
// depends on ttcbm_pkg and ttc_brake_controller_mux_core

module ttcbm_checker (
  input logic               clk,
  input logic               rst,
  input logic               result_valid,
  input logic               result_stall,
  input ttcbm_pkg::result_t result
);

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // at most one driver enabled
  a_mux_onehot: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $onehot0(result.mux_select))
    else $error("mux select not one-hot");

  // a collision clears the mux, disarms and sets the status
  a_collision_effect: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.collision_now |->
      result.mux_select == '0 && !result.safety_armed &&
      result.collision_flag && result.mux_published && result.last)
    else $error("collision result inconsistent");

  // only a publication can be followed by more results of the same item
  a_first_is_pub: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> result.mux_published && !result.collision_now)
    else $error("non-final result without publication");

  // a collision transfer always shows a nonzero count
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.collision_now |-> result.collision_total != '0)
    else $error("collision with zero count");

endmodule

bind ttc_brake_controller_mux_core ttcbm_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
